// ===== hw/rtl/sorted_table_binary_search_unit_assert.svh =====
// Assertion macros for the sorted table binary search unit.
// Used by the top level only; no other dependencies.
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define STBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/stbs_pkg.sv =====
// Shared types, codes and helpers of the sorted table binary search unit.
// No dependencies.
`default_nettype none
package stbs_pkg;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_CMP   = 4'b0100,
        S_FCMP  = 4'b1000
    } state_t;

    localparam logic       ACT_LOAD    = 1'b0;
    localparam logic       ACT_SEARCH  = 1'b1;
    localparam logic       MODE_EARLY  = 1'b0;
    localparam logic       MODE_LOWER  = 1'b1;
    localparam logic [1:0] REG_LENGTH  = 2'd0;
    localparam logic [1:0] REG_MODE    = 2'd1;

    function automatic logic [3:0] sat_add(input logic [3:0] a, input logic [1:0] b);
        logic [4:0] sum;
        sum = {1'b0, a} + {3'b000, b};
        sat_add = sum[4] ? 4'hF : sum[3:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/stbs_ram.sv =====
// Generic single-clock RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                                      clk,
    input  wire                                      wr_en,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]                         wr_data,
    input  wire                                      rd_en,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_table_binary_search_unit.sv =====
// Sorted table binary search unit: table RAM, probe sequencer, config registers.
// Depends on stbs_pkg, stbs_ram and sorted_table_binary_search_unit_assert.svh.
// Load: written at the accept edge, no result. Search: probes read in S_CHECK, compare in
// S_CMP; strobe from S_CMP on an early-exit hit, from S_CHECK on an early-exit miss or an
// empty table, from S_FCMP in lower-bound mode; next word can start with the strobe.
// Reset clears state, done, probe count, config; table undefined until loaded; no stall.
`default_nettype none
`include "sorted_table_binary_search_unit_assert.svh"
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         action,
    input  wire  [4:0]  entry_index,
    input  wire  [31:0] entry_value,
    input  wire  [31:0] search_key,
    output logic        done,
    output logic        found,
    output logic [4:0]  position,
    output logic [3:0]  probe_count,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [7:0]  cfg_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    stbs_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   first_reg, first_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [ADDR_W-1:0]  mid_reg, mid_next;
    logic [31:0]        key_reg, key_next;
    logic               mode_reg, mode_next;
    logic [3:0]         count_reg, count_next;
    logic [5:0]         length_reg;
    logic               cfg_mode_reg;
    logic               done_reg, done_next;
    logic               found_reg, found_next;
    logic [4:0]         pos_reg, pos_next;

    logic [CNT_W-1:0]   len_eff;
    logic [CNT_W:0]     mid_sum;
    logic [ADDR_W-1:0]  mid_calc;
    logic               accept;
    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [31:0]        ram_rd_data;

    assign accept    = start && (state_reg == stbs_pkg::S_IDLE);
    assign busy      = (state_reg != stbs_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign ram_wr_en = accept && (action == stbs_pkg::ACT_LOAD)
                       && (32'(entry_index) < TABLE_DEPTH);

    assign len_eff  = (32'(length_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(length_reg);
    assign mid_sum  = {1'b0, first_reg} + {1'b0, hi_reg} - (CNT_W+1)'(1);
    assign mid_calc = ADDR_W'(mid_sum >> 1);

    stbs_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(entry_index)),
        .wr_data (entry_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        first_next  = first_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        key_next    = key_reg;
        mode_next   = mode_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        pos_next    = pos_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = mid_calc;
        unique case (state_reg)
            stbs_pkg::S_IDLE:
            begin
                if (accept && (action == stbs_pkg::ACT_SEARCH))
                begin
                    key_next   = search_key;
                    mode_next  = cfg_mode_reg;
                    first_next = '0;
                    hi_next    = len_eff;
                    count_next = '0;
                    state_next = stbs_pkg::S_CHECK;
                end
            end
            stbs_pkg::S_CHECK:
            begin
                if (mode_reg == stbs_pkg::MODE_EARLY)
                begin
                    if (first_reg < hi_reg)
                    begin
                        ram_rd_en  = 1'b1;
                        mid_next   = mid_calc;
                        state_next = stbs_pkg::S_CMP;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                        pos_next   = '0;
                        state_next = stbs_pkg::S_IDLE;
                    end
                end
                else if (({1'b0, first_reg} + (CNT_W+1)'(1)) < {1'b0, hi_reg})
                begin
                    ram_rd_en  = 1'b1;
                    mid_next   = mid_calc;
                    state_next = stbs_pkg::S_CMP;
                end
                else
                begin
                    count_next = stbs_pkg::sat_add(count_reg, 2'd1);
                    if (hi_reg == '0)
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                        pos_next   = '0;
                        state_next = stbs_pkg::S_IDLE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(first_reg);
                        state_next  = stbs_pkg::S_FCMP;
                    end
                end
            end
            stbs_pkg::S_CMP:
            begin
                count_next = stbs_pkg::sat_add(count_reg, 2'd2);
                state_next = stbs_pkg::S_CHECK;
                if (mode_reg == stbs_pkg::MODE_EARLY)
                begin
                    if ($signed(key_reg) < $signed(ram_rd_data))
                    begin
                        hi_next = CNT_W'(mid_reg);
                    end
                    else if ($signed(key_reg) > $signed(ram_rd_data))
                    begin
                        first_next = CNT_W'(mid_reg) + CNT_W'(1);
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b1;
                        pos_next   = 5'(mid_reg);
                        state_next = stbs_pkg::S_IDLE;
                    end
                end
                else if ($signed(key_reg) > $signed(ram_rd_data))
                begin
                    first_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
            end
            stbs_pkg::S_FCMP:
            begin
                done_next  = 1'b1;
                found_next = (key_reg == ram_rd_data);
                pos_next   = (key_reg == ram_rd_data) ? 5'(first_reg) : 5'd0;
                state_next = stbs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = stbs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= stbs_pkg::S_IDLE;
            done_reg     <= 1'b0;
            count_reg    <= '0;
            length_reg   <= '0;
            cfg_mode_reg <= stbs_pkg::MODE_EARLY;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    stbs_pkg::REG_LENGTH: length_reg   <= cfg_data[5:0];
                    stbs_pkg::REG_MODE:   cfg_mode_reg <= cfg_data[0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        mode_reg  <= mode_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign position    = pos_reg;
    assign probe_count = count_reg;

    `STBS_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, state_reg == stbs_pkg::S_IDLE,
                     "result word while sequencer busy")
    `STBS_ASSERT_NEXT(a_search_busy, clk, rst_n,
                      accept && (action == stbs_pkg::ACT_SEARCH), busy,
                      "search word accepted but sequencer idle")
    `STBS_ASSERT_NOW(a_miss_pos, clk, rst_n, done_reg && !found_reg, pos_reg == 5'd0,
                     "miss word with nonzero position")

endmodule
`default_nettype wire

// ===== tb/sv/tb_sorted_table_binary_search_unit.sv =====
// Testbench for sorted_table_binary_search_unit: loads sorted and unsorted tables, searches
// them in both modes across several lengths, and checks each strobed result against a
// built-in lookup predictor. Depends on stbs_pkg and the unit's RTL.
module tb_sorted_table_binary_search_unit;

    typedef struct {
        logic        action;
        logic [4:0]  idx;
        logic [31:0] value;
        logic [31:0] key;
        int          gap;
        bit          drain;
    } item_word_t;

    typedef struct {
        logic [31:0] key;
        logic        found;
        logic [4:0]  position;
        logic [3:0]  probe_count;
    } lookup_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        action = stbs_pkg::ACT_LOAD;
    logic [4:0]  entry_index = '0;
    logic [31:0] entry_value = '0;
    logic [31:0] search_key = '0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = stbs_pkg::REG_LENGTH;
    logic [7:0]  cfg_data = '0;
    wire         busy;
    wire         done;
    wire         found;
    wire  [4:0]  position;
    wire  [3:0]  probe_count;
    wire         cfg_ready;

    item_word_t  issue_q[$];
    lookup_t     lookup_q[$];
    item_word_t  next_word;
    lookup_t     want;

    logic [31:0] shadow_tbl [0:31];
    logic [5:0]  shadow_len = '0;
    logic        shadow_mode = stbs_pkg::MODE_EARLY;
    logic [31:0] plan_tbl [0:31];
    int          plan_len = 0;

    logic        took = 1'b0;
    int          idle_left = 0;
    bit          no_idle = 1'b0;
    int          errors = 0;

    sorted_table_binary_search_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .done        (done),
        .found       (found),
        .position    (position),
        .probe_count (probe_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic lookup_t lookup_key(input logic [31:0] key);
        lookup_t            r;
        int                 len, first, last, mid, cnt, pos;
        bit                 hit;
        logic signed [31:0] k, p;
        k = key;
        len = (shadow_len > 32) ? 32 : int'(shadow_len);
        first = 0;
        last = len - 1;
        cnt = 0;
        pos = 0;
        hit = 1'b0;
        if (shadow_mode == stbs_pkg::MODE_EARLY)
        begin
            while (first <= last && !hit)
            begin
                mid = (first + last) / 2;
                p = shadow_tbl[mid];
                cnt += 2;
                if (k < p)
                    last = mid - 1;
                else if (k > p)
                    first = mid + 1;
                else
                begin
                    hit = 1'b1;
                    pos = mid;
                end
            end
        end
        else
        begin
            while (first < last)
            begin
                mid = (first + last) / 2;
                p = shadow_tbl[mid];
                cnt += 2;
                if (k > p)
                    first = mid + 1;
                else
                    last = mid;
            end
            cnt += 1;
            if (last >= 0)
            begin
                p = shadow_tbl[first];
                if (k == p)
                begin
                    hit = 1'b1;
                    pos = first;
                end
            end
        end
        r.key = key;
        r.found = hit;
        r.position = hit ? pos[4:0] : 5'd0;
        r.probe_count = (cnt > 15) ? 4'd15 : cnt[3:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= 50)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // hold a word until taken, then idle for its gap
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || took)
        begin
            if (idle_left > 0)
            begin
                start <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (issue_q.size() == 0 || (issue_q[0].drain && lookup_q.size() != 0))
                start <= 1'b0;
            else
            begin
                next_word = issue_q.pop_front();
                action <= next_word.action;
                entry_index <= next_word.idx;
                entry_value <= next_word.value;
                search_key <= next_word.key;
                idle_left <= next_word.gap;
                start <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        took <= start && !busy;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (lookup_q.size() == 0)
                    flag_mismatch("result strobe with no search pending");
                else
                begin
                    want = lookup_q.pop_front();
                    if (found !== want.found)
                        flag_mismatch($sformatf("key %h: found %b, want %b",
                                                want.key, found, want.found));
                    if (position !== want.position)
                        flag_mismatch($sformatf("key %h: position %0d, want %0d",
                                                want.key, position, want.position));
                    if (probe_count !== want.probe_count)
                        flag_mismatch($sformatf("key %h: probe_count %0d, want %0d",
                                                want.key, probe_count, want.probe_count));
                end
            end
            if (start && !busy)
            begin
                if (action == stbs_pkg::ACT_LOAD)
                    shadow_tbl[entry_index] = entry_value;
                else
                    lookup_q.push_back(lookup_key(search_key));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    stbs_pkg::REG_LENGTH: shadow_len = cfg_data[5:0];
                    stbs_pkg::REG_MODE:   shadow_mode = cfg_data[0];
                    default:              ;
                endcase
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_load(input logic [4:0] idx, input logic [31:0] val);
        item_word_t w;
        w.action = stbs_pkg::ACT_LOAD;
        w.idx = idx;
        w.value = val;
        w.key = $urandom;
        w.gap = pick_gap();
        w.drain = 1'b0;
        plan_tbl[idx] = val;
        issue_q.push_back(w);
    endtask

    task automatic queue_search(input logic [31:0] key, input bit drain);
        item_word_t w;
        w.action = stbs_pkg::ACT_SEARCH;
        w.idx = 5'($urandom_range(0, 31));
        w.value = $urandom;
        w.key = key;
        w.gap = pick_gap();
        w.drain = drain;
        issue_q.push_back(w);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int len, input logic mode);
        logic [7:0] d;
        d = $urandom;
        d[5:0] = 6'(len);
        write_reg(stbs_pkg::REG_LENGTH, d);
        d = $urandom;
        d[0] = mode;
        write_reg(stbs_pkg::REG_MODE, d);
        plan_len = len;
    endtask

    task automatic settle();
        do @(posedge clk); while (issue_q.size() != 0 || start || lookup_q.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic reload_sorted();
        longint             v;
        int                 step_max, pick;
        logic signed [31:0] s;
        pick = $urandom_range(0, 2);
        step_max = (pick == 0) ? 3 : (pick == 1) ? 5000 : 134217727;
        s = $urandom;
        v = (pick == 2) ? -64'sd2147483648 + $urandom_range(0, 1 << 20) : longint'(s);
        for (int i = 0; i < 32; i++)
        begin
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            queue_load(5'(i), v[31:0]);
            v += $urandom_range(0, step_max);
        end
    endtask

    function automatic logic [31:0] pick_key();
        int r, n, j;
        n = (plan_len > 32) ? 32 : plan_len;
        r = $urandom_range(0, 99);
        j = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if (n > 0 && r < 45)
            return plan_tbl[j];
        if (n > 0 && r < 65)
            return plan_tbl[j] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
        if (r < 75)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    initial
    begin
        logic [31:0] probe_keys [0:6];
        logic [31:0] v;
        int          r, len;
        probe_keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_EC78,
                       32'd500, 32'h7FFF_FFFE, 32'h8000_0001};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table in both modes
        queue_search(32'd0, 1'b1);
        queue_search(32'h8000_0000, 1'b0);
        settle();
        set_config(0, stbs_pkg::MODE_LOWER);
        queue_search(32'h7FFF_FFFF, 1'b0);
        for (int i = 0; i < 32; i++)
        begin
            v = (i - 15) * 1000;
            if (i == 0)
                v = 32'h8000_0000;
            else if (i == 31)
                v = 32'h7FFF_FFFF;
            else if (i == 11)
                v = (10 - 15) * 1000;
            queue_load(5'(i), v);
        end
        settle();
        set_config(32, stbs_pkg::MODE_EARLY);
        foreach (probe_keys[i])
            queue_search(probe_keys[i], i == 0);
        settle();
        set_config(32, stbs_pkg::MODE_LOWER);
        foreach (probe_keys[i])
            queue_search(probe_keys[i], 1'b0);
        settle();
        set_config(1, stbs_pkg::MODE_EARLY);
        queue_search(plan_tbl[0], 1'b0);
        queue_search(32'd0, 1'b0);
        settle();
        // lengths above the depth saturate
        set_config(63, stbs_pkg::MODE_LOWER);
        queue_search(plan_tbl[31], 1'b0);
        queue_search(32'd1, 1'b0);
        settle();
        set_config(33, stbs_pkg::MODE_EARLY);
        queue_search(plan_tbl[20], 1'b0);

        for (int ph = 0; ph < 12; ph++)
        begin
            settle();
            r = $urandom_range(0, 99);
            if (r < 25)
                len = 32;
            else if (r < 35)
                len = 0;
            else if (r < 45)
                len = $urandom_range(33, 63);
            else
                len = $urandom_range(1, 31);
            set_config(len, 1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1))
                reload_sorted();
            for (int n = 0; n < 125; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_load(5'($urandom_range(0, 31)), $urandom);
                else
                    queue_search(pick_key(), n == 0 || $urandom_range(0, 49) == 0);
            end
        end
        settle();
        if (lookup_q.size() != 0)
            flag_mismatch($sformatf("%0d searches never returned", lookup_q.size()));
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d searches pending", lookup_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sorted_table_binary_search_unit.f =====
+incdir+hw/rtl
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_ram.sv
hw/rtl/sorted_table_binary_search_unit.sv
tb/sv/tb_sorted_table_binary_search_unit.sv
